// ----- rtl/sle_pkg.sv -----
// Shared types and constants for the sync/length frame extractor.
`timescale 1ns / 1ps
`default_nettype none

package sle_pkg;

	// The length field is always two bytes, little-endian.
	localparam int LENGTH_BYTES = 2;
	localparam int CFG_IDX_W    = 8;

	localparam logic [CFG_IDX_W-1:0] REG_SYNC_PATTERN   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_CAPACITY = 8'd1;

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_LEN_LO,
		PH_LEN_HI,
		PH_BODY
	} phase_t;

	// One command from the classifier to the output sequencer. A header command
	// expands to the sync bytes and both length bytes; otherwise one byte is sent.
	typedef struct packed {
		logic        hdr;
		logic [63:0] win;
		logic [7:0]  len_lo;
		logic [7:0]  data;
		logic        last;
	} cmd_t;

endpackage

`default_nettype wire

// ----- rtl/sle_front.sv -----
// Front end: sync hunt, length capture and frame body classification.
`timescale 1ns / 1ps
`default_nettype none

module sle_front #(
	parameter int SYNC_BYTES = 4
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               take,
	input  wire logic [7:0]         data_byte,
	input  wire logic [63:0]        sync_pattern,
	input  wire logic [15:0]        frame_capacity,
	output logic                    cmd_push,
	output sle_pkg::cmd_t           cmd
);

	localparam int WIN_W  = 8 * SYNC_BYTES;
	localparam int FILL_W = $clog2(SYNC_BYTES + 1);
	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(SYNC_BYTES);
	localparam logic [15:0] HDR_LEN = 16'(SYNC_BYTES + sle_pkg::LENGTH_BYTES);
	localparam logic [15:0] SYNC_CNT = 16'(SYNC_BYTES);

	sle_pkg::phase_t    phase_q, phase_d;
	logic [WIN_W-1:0]   win_q, win_d, win_shift;
	logic [FILL_W-1:0]  fill_q, fill_d, fill_inc;
	logic [7:0]         len_lo_q, len_lo_d;
	logic [15:0]        frame_len_q, frame_len_d;
	logic [15:0]        count_q, count_d, count_inc;
	logic [15:0]        len_full;
	logic               hunt_restart;

	always_comb begin
		win_shift = win_q >> 8;
		win_shift[WIN_W-1 -: 8] = data_byte;
		fill_inc  = (fill_q < FILL_FULL) ? fill_q + 1'b1 : fill_q;
		count_inc = count_q + 16'd1;
		len_full  = {data_byte, len_lo_q};
	end

	always_comb begin
		phase_d      = phase_q;
		win_d        = win_q;
		fill_d       = fill_q;
		len_lo_d     = len_lo_q;
		frame_len_d  = frame_len_q;
		count_d      = count_q;
		hunt_restart = 1'b0;
		cmd_push     = 1'b0;
		cmd.hdr      = 1'b0;
		cmd.win      = 64'(win_q);
		cmd.len_lo   = len_lo_q;
		cmd.data     = data_byte;
		cmd.last     = 1'b0;
		unique case (phase_q)
			sle_pkg::PH_HUNT: begin
				win_d  = win_shift;
				fill_d = fill_inc;
				if (fill_inc == FILL_FULL && win_shift == sync_pattern[WIN_W-1:0]) begin
					phase_d = sle_pkg::PH_LEN_LO;
					count_d = SYNC_CNT;
				end
			end
			sle_pkg::PH_LEN_LO: begin
				len_lo_d = data_byte;
				count_d  = count_inc;
				phase_d  = sle_pkg::PH_LEN_HI;
			end
			sle_pkg::PH_LEN_HI: begin
				count_d = HDR_LEN;
				if (len_full < HDR_LEN) begin
					hunt_restart = 1'b1;
				end else if (len_full > frame_capacity) begin
					if (HDR_LEN >= frame_capacity) begin
						hunt_restart = 1'b1;
					end else begin
						// A zero frame length marks a frame that is swallowed.
						frame_len_d = 16'd0;
						phase_d     = sle_pkg::PH_BODY;
					end
				end else begin
					cmd_push = 1'b1;
					cmd.hdr  = 1'b1;
					cmd.last = (len_full == HDR_LEN);
					if (len_full == HDR_LEN) begin
						hunt_restart = 1'b1;
					end else begin
						frame_len_d = len_full;
						phase_d     = sle_pkg::PH_BODY;
					end
				end
			end
			sle_pkg::PH_BODY: begin
				count_d = count_inc;
				if (frame_len_q == 16'd0) begin
					hunt_restart = (count_inc >= frame_capacity);
				end else begin
					cmd_push     = 1'b1;
					cmd.last     = (count_inc >= frame_len_q);
					hunt_restart = (count_inc >= frame_len_q);
				end
			end
			default: begin
				hunt_restart = 1'b1;
			end
		endcase
		if (hunt_restart) begin
			phase_d     = sle_pkg::PH_HUNT;
			win_d       = '0;
			fill_d      = '0;
			len_lo_d    = 8'd0;
			frame_len_d = 16'd0;
			count_d     = 16'd0;
		end
		if (!take) begin
			cmd_push = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= sle_pkg::PH_HUNT;
			win_q       <= '0;
			fill_q      <= '0;
			len_lo_q    <= 8'd0;
			frame_len_q <= 16'd0;
			count_q     <= 16'd0;
		end else if (take) begin
			phase_q     <= phase_d;
			win_q       <= win_d;
			fill_q      <= fill_d;
			len_lo_q    <= len_lo_d;
			frame_len_q <= frame_len_d;
			count_q     <= count_d;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/sle_cmd_fifo.sv -----
// Command queue between the classifier and the output sequencer.
`timescale 1ns / 1ps
`default_nettype none

module sle_cmd_fifo #(
	parameter int DEPTH = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_en,
	input  wire sle_pkg::cmd_t wr_data,
	output logic               full,
	input  wire logic          rd_en,
	output sle_pkg::cmd_t      rd_data,
	output logic               empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	sle_pkg::cmd_t     mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_wr, do_rd;

	assign full    = (count_q == CNT_FULL);
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/sle_back.sv -----
// Output sequencer: expands queued commands into frame bytes.
`timescale 1ns / 1ps
`default_nettype none

module sle_back #(
	parameter int SYNC_BYTES = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire sle_pkg::cmd_t head,
	input  wire logic          head_empty,
	output logic               head_pop,
	input  wire logic          pop,
	output logic               empty,
	output logic [7:0]         out_byte,
	output logic               first_flag,
	output logic               last_flag
);

	localparam int IDX_W = $clog2(SYNC_BYTES + 2);
	localparam logic [IDX_W-1:0] IDX_LEN_LO = IDX_W'(SYNC_BYTES);
	localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(SYNC_BYTES + 1);

	sle_pkg::cmd_t     cur_q;
	logic              valid_q;
	logic [IDX_W-1:0]  idx_q;
	logic              done;

	assign empty    = !valid_q;
	assign done     = !cur_q.hdr || (idx_q == IDX_LAST);
	assign head_pop = !head_empty && (!valid_q || (pop && done));

	always_comb begin
		out_byte   = cur_q.data;
		first_flag = 1'b0;
		last_flag  = cur_q.last;
		if (cur_q.hdr) begin
			if (idx_q < IDX_LEN_LO) begin
				out_byte   = cur_q.win[8*idx_q +: 8];
				first_flag = (idx_q == '0);
				last_flag  = 1'b0;
			end else if (idx_q == IDX_LEN_LO) begin
				out_byte  = cur_q.len_lo;
				last_flag = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (head_pop) begin
			cur_q <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (head_pop) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (pop && valid_q) begin
			if (done) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/sync_length_frame_extractor.sv -----
// Top level of the sync-word, length-prefixed frame extractor.
`timescale 1ns / 1ps
`default_nettype none

// Takes one raw byte per cycle while full is low and delivers the bytes of
// each valid frame, header included, with first_flag on the first sync byte
// and last_flag on the final byte. Body bytes pass at one per cycle while
// pop is held; a frame header expands into SYNC_BYTES+2 output transactions,
// one per cycle, so one input byte occupies the sequencer for all of them.
// A QUEUE_DEPTH-entry command queue decouples the classifier from the
// sequencer, and full rises whenever that queue fills. Oversized frames are
// swallowed without output, up to frame_capacity bytes. Configuration writes
// are always ready and should be issued only while no frame is in progress.
module sync_length_frame_extractor #(
	parameter int SYNC_BYTES  = 4,
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	output logic                               full,
	input  wire logic [7:0]                    data_byte,
	output logic                               empty,
	input  wire logic                          pop,
	output logic [7:0]                         out_byte,
	output logic                               first_flag,
	output logic                               last_flag,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [sle_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [63:0]                   cfg_data
);

	logic [63:0]    sync_pattern_q;
	logic [15:0]    frame_capacity_q;
	logic           take;
	logic           cmd_push;
	sle_pkg::cmd_t  cmd;
	sle_pkg::cmd_t  head;
	logic           head_empty;
	logic           head_pop;

	assign cfg_ready = 1'b1;
	assign take      = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_pattern_q   <= 64'd0;
			frame_capacity_q <= 16'd4096;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == sle_pkg::REG_SYNC_PATTERN) begin
				sync_pattern_q <= cfg_data;
			end else if (cfg_index == sle_pkg::REG_FRAME_CAPACITY) begin
				frame_capacity_q <= cfg_data[15:0];
			end
		end
	end

	sle_front #(
		.SYNC_BYTES (SYNC_BYTES)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.take           (take),
		.data_byte      (data_byte),
		.sync_pattern   (sync_pattern_q),
		.frame_capacity (frame_capacity_q),
		.cmd_push       (cmd_push),
		.cmd            (cmd)
	);

	sle_cmd_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (cmd),
		.full    (full),
		.rd_en   (head_pop),
		.rd_data (head),
		.empty   (head_empty)
	);

	sle_back #(
		.SYNC_BYTES (SYNC_BYTES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_empty (head_empty),
		.head_pop   (head_pop),
		.pop        (pop),
		.empty      (empty),
		.out_byte   (out_byte),
		.first_flag (first_flag),
		.last_flag  (last_flag)
	);

endmodule

`default_nettype wire
